// File: hdl/sle_pkg.sv
package sle_pkg;

   // geometry
   localparam int MaxLine = 32;
   localparam int AddrW   = $clog2(MaxLine);
   localparam int LimitW  = 6;
   localparam int CsrAddrW = 3;

   // register map
   localparam logic [CsrAddrW-1:0] CSR_LINE_LIMIT = 3'd0;
   localparam logic [LimitW-1:0]   LIMIT_RESET    = 6'd32;
   localparam logic [LimitW-1:0]   LIMIT_MIN      = 6'd2;
   localparam logic [LimitW-1:0]   LIMIT_MAX      = 6'(MaxLine);

   // result kinds
   localparam logic [1:0] KIND_ECHO = 2'd0;
   localparam logic [1:0] KIND_DATA = 2'd1;
   localparam logic [1:0] KIND_END  = 2'd2;

   // character codes
   localparam logic [7:0] CH_CTRL_C = 8'd3;
   localparam logic [7:0] CH_BS     = 8'd8;
   localparam logic [7:0] CH_LF     = 8'd10;
   localparam logic [7:0] CH_CR     = 8'd13;
   localparam logic [7:0] CH_SPACE  = 8'd32;
   localparam logic [7:0] CH_CARET  = 8'd94;
   localparam logic [7:0] CH_UPPER_C = 8'd67;
   localparam logic [7:0] CH_DEL    = 8'd127;

   // echo sequences
   typedef enum logic [1:0] {
      SEQ_CHAR    = 2'd0,
      SEQ_NEWLINE = 2'd1,
      SEQ_ERASE   = 2'd2,
      SEQ_CTRL_C  = 2'd3
   } seq_type;

   // index of the final echo beat of a sequence
   function automatic logic [1:0] seq_last_idx(input seq_type seq);
      logic [1:0] r;
      case (seq)
         SEQ_CHAR:    r = 2'd0;
         SEQ_NEWLINE: r = 2'd1;
         SEQ_ERASE:   r = 2'd2;
         SEQ_CTRL_C:  r = 2'd3;
         default:     r = 2'd0;
      endcase
      return r;
   endfunction

   // echo byte at a position of a sequence
   function automatic logic [7:0] seq_byte(input seq_type seq, input logic [1:0] idx,
                                           input logic [7:0] ch);
      logic [7:0] r;
      r = ch;
      case (seq)
         SEQ_CHAR:    r = ch;
         SEQ_NEWLINE: r = (idx == 2'd0) ? CH_CR : CH_LF;
         SEQ_ERASE:   r = (idx == 2'd1) ? CH_SPACE : CH_BS;
         SEQ_CTRL_C: begin
            case (idx)
               2'd0:    r = CH_CARET;
               2'd1:    r = CH_UPPER_C;
               2'd2:    r = CH_CR;
               default: r = CH_LF;
            endcase
         end
         default:     r = ch;
      endcase
      return r;
   endfunction

   // sequencer states
   typedef enum logic [4:0] {
      ST_IDLE = 5'b00001,
      ST_ECHO = 5'b00010,
      ST_READ = 5'b00100,
      ST_DATA = 5'b01000,
      ST_END  = 5'b10000
   } state_type;

endpackage

// File: hdl/serial_line_editor_top.sv
// channel   direction  ports                                              beat
// req       in         req_valid req_stall req_rx_byte                    one received byte
// rsp       out        rsp_valid rsp_stall rsp_out_kind rsp_out_byte      one echo, data or end
//                      rsp_line_length rsp_last
// csr       in/out     psel penable pwrite pready paddr pwdata prdata     line_limit at 0
//
// one byte at a time: a new byte is taken only in idle, while the output register may still wait
// each echo beat and the end marker are loaded into the output register from the sequencer, each
// line data byte is first read from the line memory (ST_READ), then loaded into the output register
// synchronous active-high reset clears the sequencer state, fill and output valid and sets the limit to 32;
// the line memory is not reset; rsp_stall holds the output register and the sequencer waits on it
module serial_line_editor_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [7:0]                      req_rx_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [1:0]                      rsp_out_kind,
   output logic [7:0]                      rsp_out_byte,
   output logic [4:0]                      rsp_line_length,
   output logic                            rsp_last,
   input  logic                            psel,
   input  logic                            penable,
   input  logic                            pwrite,
   input  logic [sle_pkg::CsrAddrW-1:0]    paddr,
   input  logic [31:0]                     pwdata,
   output logic [31:0]                     prdata,
   output logic                            pready
);

   sle_pkg::state_type state_ff, state_in;
   sle_pkg::seq_type   seq_ff, seq_in;

   logic [sle_pkg::LimitW-1:0] limit_ff, limit_in;
   logic [sle_pkg::AddrW-1:0]  fill_ff, fill_in;
   logic [sle_pkg::AddrW-1:0]  len_ff, len_in;
   logic [sle_pkg::AddrW-1:0]  rd_idx_ff, rd_idx_in;
   logic [1:0]                 echo_idx_ff, echo_idx_in;
   logic [7:0]                 char_ff, char_in;
   logic                       finish_ff, finish_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_kind_ff, rsp_kind_in;
   logic [7:0]                 rsp_byte_ff, rsp_byte_in;
   logic [4:0]                 rsp_len_ff, rsp_len_in;
   logic                       rsp_last_ff, rsp_last_in;

   logic [7:0] line_mem [sle_pkg::MaxLine];
   logic [7:0] rd_data_ff;

   logic                       accept;
   logic                       out_free;
   logic                       load;
   logic                       mem_wr;
   logic                       csr_wr;
   logic                       is_newline, is_erase, is_ctrl_c, is_print;
   logic [sle_pkg::LimitW-1:0] lim_eff;
   logic [sle_pkg::LimitW-1:0] new_fill;

   // configuration port
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready && (paddr == sle_pkg::CSR_LINE_LIMIT);
   assign limit_in = csr_wr ? pwdata[sle_pkg::LimitW-1:0] : limit_ff;

   always_comb begin
      prdata = '0;
      if (paddr == sle_pkg::CSR_LINE_LIMIT) begin
         prdata = {{(32 - sle_pkg::LimitW){1'b0}}, limit_ff};
      end
   end

   // byte classes and limit clamp
   assign is_newline = (req_rx_byte == sle_pkg::CH_CR) || (req_rx_byte == sle_pkg::CH_LF);
   assign is_erase   = (req_rx_byte == sle_pkg::CH_BS) || (req_rx_byte == sle_pkg::CH_DEL);
   assign is_ctrl_c  = (req_rx_byte == sle_pkg::CH_CTRL_C);
   assign is_print   = (req_rx_byte >= sle_pkg::CH_SPACE) && (req_rx_byte < sle_pkg::CH_DEL);

   always_comb begin
      if (limit_ff < sle_pkg::LIMIT_MIN) begin
         lim_eff = sle_pkg::LIMIT_MIN;
      end else if (limit_ff > sle_pkg::LIMIT_MAX) begin
         lim_eff = sle_pkg::LIMIT_MAX;
      end else begin
         lim_eff = limit_ff;
      end
   end

   assign new_fill = {1'b0, fill_ff} + 6'd1;

   // handshakes
   assign req_stall = (state_ff != sle_pkg::ST_IDLE);
   assign accept    = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign mem_wr    = accept && is_print;

   // sequencer
   always_comb begin
      state_in    = state_ff;
      seq_in      = seq_ff;
      fill_in     = fill_ff;
      len_in      = len_ff;
      rd_idx_in   = rd_idx_ff;
      echo_idx_in = echo_idx_ff;
      char_in     = char_ff;
      finish_in   = finish_ff;
      load        = 1'b0;
      rsp_kind_in = rsp_kind_ff;
      rsp_byte_in = rsp_byte_ff;
      rsp_len_in  = rsp_len_ff;
      rsp_last_in = rsp_last_ff;
      unique case (state_ff)
         sle_pkg::ST_IDLE: begin
            echo_idx_in = 2'd0;
            rd_idx_in   = '0;
            char_in     = req_rx_byte;
            if (accept) begin
               if (is_newline) begin
                  seq_in    = sle_pkg::SEQ_NEWLINE;
                  finish_in = 1'b1;
                  len_in    = fill_ff;
                  fill_in   = '0;
                  state_in  = sle_pkg::ST_ECHO;
               end else if (is_erase) begin
                  if (fill_ff != '0) begin
                     seq_in    = sle_pkg::SEQ_ERASE;
                     finish_in = 1'b0;
                     fill_in   = fill_ff - 1'b1;
                     state_in  = sle_pkg::ST_ECHO;
                  end
               end else if (is_ctrl_c) begin
                  seq_in    = sle_pkg::SEQ_CTRL_C;
                  finish_in = 1'b1;
                  len_in    = '0;
                  fill_in   = '0;
                  state_in  = sle_pkg::ST_ECHO;
               end else if (is_print) begin
                  seq_in   = sle_pkg::SEQ_CHAR;
                  state_in = sle_pkg::ST_ECHO;
                  if (new_fill >= lim_eff - 6'd1) begin
                     finish_in = 1'b1;
                     len_in    = new_fill[sle_pkg::AddrW-1:0];
                     fill_in   = '0;
                  end else begin
                     finish_in = 1'b0;
                     fill_in   = new_fill[sle_pkg::AddrW-1:0];
                  end
               end
            end
         end
         sle_pkg::ST_ECHO: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = sle_pkg::KIND_ECHO;
               rsp_byte_in = sle_pkg::seq_byte(seq_ff, echo_idx_ff, char_ff);
               rsp_len_in  = '0;
               rsp_last_in = 1'b0;
               echo_idx_in = echo_idx_ff + 2'd1;
               if (echo_idx_ff == sle_pkg::seq_last_idx(seq_ff)) begin
                  if (!finish_ff) begin
                     rsp_last_in = 1'b1;
                     state_in    = sle_pkg::ST_IDLE;
                  end else if (len_ff == '0) begin
                     state_in = sle_pkg::ST_END;
                  end else begin
                     state_in = sle_pkg::ST_READ;
                  end
               end
            end
         end
         sle_pkg::ST_READ: begin
            state_in = sle_pkg::ST_DATA;
         end
         sle_pkg::ST_DATA: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = sle_pkg::KIND_DATA;
               rsp_byte_in = rd_data_ff;
               rsp_len_in  = '0;
               rsp_last_in = 1'b0;
               rd_idx_in   = rd_idx_ff + 1'b1;
               state_in    = (rd_idx_ff == len_ff - 1'b1) ? sle_pkg::ST_END : sle_pkg::ST_READ;
            end
         end
         sle_pkg::ST_END: begin
            if (out_free) begin
               load        = 1'b1;
               rsp_kind_in = sle_pkg::KIND_END;
               rsp_byte_in = '0;
               rsp_len_in  = len_ff;
               rsp_last_in = 1'b1;
               state_in    = sle_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = sle_pkg::ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = load || (rsp_valid_ff && rsp_stall);

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= sle_pkg::ST_IDLE;
         fill_ff      <= '0;
         limit_ff     <= sle_pkg::LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         fill_ff      <= fill_in;
         limit_ff     <= limit_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // item and output payload registers
   always_ff @(posedge clock) begin
      seq_ff      <= seq_in;
      len_ff      <= len_in;
      rd_idx_ff   <= rd_idx_in;
      echo_idx_ff <= echo_idx_in;
      char_ff     <= char_in;
      finish_ff   <= finish_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_byte_ff <= rsp_byte_in;
      rsp_len_ff  <= rsp_len_in;
      rsp_last_ff <= rsp_last_in;
   end

   // line memory: write on a stored byte, registered read during readout
   always_ff @(posedge clock) begin
      if (mem_wr) begin
         line_mem[fill_ff] <= req_rx_byte;
      end
      if (state_ff == sle_pkg::ST_READ) begin
         rd_data_ff <= line_mem[rd_idx_ff];
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_kind    = rsp_kind_ff;
   assign rsp_out_byte    = rsp_byte_ff;
   assign rsp_line_length = rsp_len_ff;
   assign rsp_last        = rsp_last_ff;

   // a resting line never holds a full buffer
   a_fill_rest: assert property (@(posedge clock) disable iff (reset)
      (state_ff == sle_pkg::ST_IDLE) |-> (fill_ff != 5'd31))
      else $error("fill at rest reached the buffer end");

   // readout index stays inside the line being emitted
   a_rd_range: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == sle_pkg::ST_READ) || (state_ff == sle_pkg::ST_DATA)) |->
      (rd_idx_ff < len_ff))
      else $error("readout index beyond line length");

   // an end marker closes the byte's results
   a_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_out_kind == sle_pkg::KIND_END)) |-> (rsp_last && (rsp_out_byte == 8'd0)))
      else $error("end marker without last or with nonzero byte");

   // a newline, ctrl-c or printable byte blocks the input on the next cycle
   a_busy: assert property (@(posedge clock) disable iff (reset)
      (accept && (is_newline || is_ctrl_c || is_print)) |=> req_stall)
      else $error("input taken again before results were issued");

endmodule
